// File: hw/rtl/integer_text_parser_macros.svh
// ------------------------------------------------------------------------
// integer_text_parser assertion macros
// Shared concurrent assertion forms for the parser checker.
// ------------------------------------------------------------------------
`ifndef INTEGER_TEXT_PARSER_MACROS_SVH
`define INTEGER_TEXT_PARSER_MACROS_SVH

// Checked only while out of reset
`define ITP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ITP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/itp_pkg.sv
// ------------------------------------------------------------------------
// itp_pkg
// Types, constants and the digit decoder of the integer text parser.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package itp_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned OUT_W          = 64;
  localparam int unsigned RADIX_W        = 5;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 5;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_PLUS  = 8'h2B;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 5'd16;

  localparam logic             MODE_AUTO_RST  = 1'b1;
  localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PARSE_MODE  = 1'b0,
    REG_FIXED_RADIX = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_START     = 2'd0,
    PH_LEAD_ZERO = 2'd1,
    PH_DECIMAL   = 2'd2,
    PH_HEX       = 2'd3
  } phase_e;

  // Control state carried from one character to the next
  typedef struct packed {
    phase_e phase;
    logic   neg;
    logic   halted;
  } state_t;

  localparam state_t STATE_RST = '{phase: PH_START, neg: 1'b0, halted: 1'b0};

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // '0'-'9', 'a'-'f', 'A'-'F'; everything else is not a digit
  function automatic digit_t digit_of(logic [CHAR_W-1:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.val = 4'(c - 8'h37);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// File: hw/rtl/itp_step.sv
// ------------------------------------------------------------------------
// itp_step
// One character of parsing: phase decode, digit check, multiply-add,
// and the signed or fixed-radix result formed from the updated state.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_step #(
  parameter int unsigned VALUE_BITS = itp_pkg::VALUE_BITS_DEF
) (
  input  logic [itp_pkg::CHAR_W-1:0]  char_i,
  input  logic                        mode_i,
  input  logic [itp_pkg::RADIX_W-1:0] radix_i,
  input  itp_pkg::state_t             state_i,
  input  logic [VALUE_BITS-1:0]       acc_i,
  output itp_pkg::state_t             state_o,
  output logic [VALUE_BITS-1:0]       acc_o,
  output logic [itp_pkg::OUT_W-1:0]   value_o
);

  itp_pkg::digit_t             dig;
  itp_pkg::state_t             state_ph;
  logic [itp_pkg::RADIX_W-1:0] radix_sel;
  logic                        take;
  logic                        clr_acc;
  logic [VALUE_BITS-1:0]       prod;
  logic [VALUE_BITS-1:0]       auto_v;
  logic signed [VALUE_BITS-1:0] auto_s;
  logic [itp_pkg::OUT_W-1:0]   value_auto;
  logic [itp_pkg::OUT_W-1:0]   acc_wide;

  assign dig = itp_pkg::digit_of(char_i);

  // Phase decode: picks the radix and whether this character is a digit
  always_comb begin
    state_ph  = state_i;
    radix_sel = itp_pkg::RADIX_DEC;
    take      = 1'b0;
    clr_acc   = 1'b0;
    if (!state_i.halted) begin
      if (!mode_i) begin
        take      = 1'b1;
        radix_sel = radix_i;
      end else begin
        unique case (state_i.phase)
          itp_pkg::PH_START: begin
            if (char_i == itp_pkg::CHAR_MINUS) begin
              state_ph.neg   = 1'b1;
              state_ph.phase = itp_pkg::PH_DECIMAL;
            end else if (char_i == itp_pkg::CHAR_PLUS) begin
              state_ph.phase = itp_pkg::PH_DECIMAL;
            end else if (char_i == itp_pkg::CHAR_ZERO) begin
              clr_acc        = 1'b1;
              state_ph.phase = itp_pkg::PH_LEAD_ZERO;
            end else begin
              state_ph.phase = itp_pkg::PH_DECIMAL;
              take           = 1'b1;
            end
          end
          itp_pkg::PH_LEAD_ZERO: begin
            if (char_i == itp_pkg::CHAR_X) begin
              state_ph.phase = itp_pkg::PH_HEX;
            end else begin
              state_ph.phase = itp_pkg::PH_DECIMAL;
              take           = 1'b1;
            end
          end
          itp_pkg::PH_DECIMAL: begin
            take = 1'b1;
          end
          itp_pkg::PH_HEX: begin
            take      = 1'b1;
            radix_sel = itp_pkg::RADIX_HEX;
          end
          default: begin
            take = 1'b1;
          end
        endcase
      end
    end
  end

  // Multiply-add, wrapping at the accumulator width
  assign prod = VALUE_BITS'(acc_i * radix_sel);

  // A non-digit, or a digit at or above the radix, stops parsing for the rest of the string
  always_comb begin
    acc_o   = acc_i;
    state_o = state_ph;
    if (clr_acc) begin
      acc_o = '0;
    end else if (take) begin
      if (!dig.ok || ({1'b0, dig.val} >= radix_sel)) begin
        state_o.halted = 1'b1;
      end else begin
        acc_o = prod + VALUE_BITS'(dig.val);
      end
    end
  end

  // Result forms: signed auto value or low 32 bits in fixed mode
  assign auto_v     = state_o.neg ? (VALUE_BITS'(0) - acc_o) : acc_o;
  assign auto_s     = auto_v;
  assign value_auto = 64'(auto_s);
  assign acc_wide   = 64'(acc_o);
  assign value_o    = mode_i ? value_auto : {32'd0, acc_wide[31:0]};

endmodule

// File: hw/rtl/integer_text_parser.sv
// One character is taken per clock on s_axis with tlast on the final one;
// a string's result passes from the input register through the step stage
// into the result register, which drives m_axis and holds it until taken.
// Throughput is one character per cycle, set by the multiply-by-radix and
// add that carries the accumulator from one character to the next. The input
// stalls only when a final character reaches the step stage while the
// result register still holds an untaken result.
// ------------------------------------------------------------------------
// integer_text_parser
// Streaming decimal/hex integer parser with a plain config write port.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_text_parser #(
  parameter int unsigned VALUE_BITS = itp_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [itp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [itp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // character requests
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] char_code
  input  logic                           s_axis_tlast,   // is_final
  // result requests
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [63:0]                    m_axis_tdata    // [63:0] parsed_value
);

  logic                        mode_q;
  logic [itp_pkg::RADIX_W-1:0] radix_q;

  logic                        in_vld_q;
  logic [itp_pkg::CHAR_W-1:0]  char_q;
  logic                        fin_q;

  itp_pkg::state_t             state_q, state_d, state_nxt;
  logic [VALUE_BITS-1:0]       acc_q, acc_d, acc_nxt;
  logic [itp_pkg::OUT_W-1:0]   value_nxt;

  logic                        out_vld_q, out_vld_d;
  logic [itp_pkg::OUT_W-1:0]   out_data_q;

  logic                        advance;
  logic                        in_take;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= itp_pkg::MODE_AUTO_RST;
      radix_q <= itp_pkg::RADIX_RST;
    end else if (cfg_we_i) begin
      unique case (itp_pkg::cfg_reg_e'(cfg_idx_i))
        itp_pkg::REG_PARSE_MODE:  mode_q  <= cfg_data_i[0];
        itp_pkg::REG_FIXED_RADIX: radix_q <= cfg_data_i[itp_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: a final character needs room in the result register
  assign advance       = in_vld_q && (!fin_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= s_axis_tdata;
      fin_q  <= s_axis_tlast;
    end
  end

  itp_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .char_i  (char_q),
    .mode_i  (mode_q),
    .radix_i (radix_q),
    .state_i (state_q),
    .acc_i   (acc_q),
    .state_o (state_nxt),
    .acc_o   (acc_nxt),
    .value_o (value_nxt)
  );

  // Parse state: updated per character, back to start after a final one
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    if (advance) begin
      if (fin_q) begin
        state_d = itp_pkg::STATE_RST;
        acc_d   = '0;
      end else begin
        state_d = state_nxt;
        acc_d   = acc_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itp_pkg::STATE_RST;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  // Result register
  always_comb begin
    out_vld_d = out_vld_q;
    priority if (advance && fin_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fin_q) begin
      out_data_q <= value_nxt;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: hw/rtl/itp_checker.sv
// ------------------------------------------------------------------------
// itp_checker
// Port-level checks of the parser's stream handshakes, bound to the top.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_text_parser_macros.svh"

module itp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [itp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [itp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [7:0]                     s_axis_tdata,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [63:0]                    m_axis_tdata
);

  // A stalled result holds
  `ITP_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // No result shown while in reset
  `ITP_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

  // With the result side free, characters are never blocked
  `ITP_ASSERT(a_no_false_stall, clk_i, rst_ni, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input stalled with free output")

endmodule

bind integer_text_parser itp_checker u_itp_checker (.*);
